// File: rtl/mesh_peer_link_fsm_assert.svh
// Assertion macros used by the mesh peer link RTL.
`ifndef MESH_PEER_LINK_FSM_ASSERT_SVH
`define MESH_PEER_LINK_FSM_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MPL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that implies another in the same cycle.
`define MPL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define MPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpl_pkg.sv
// Package with the constants and types of the mesh peer link block.
`timescale 1ns / 1ps

package mpl_pkg;

    // Field widths.
    localparam int CategoryWidth = 8;
    localparam int LengthWidth   = 12;
    localparam int CodeWidth     = 8;
    localparam int LinkIdWidth   = 16;
    localparam int SendWidth     = 2;
    localparam int StateWidth    = 3;

    // Result queue geometry.
    localparam int QueueDepth    = 4;
    localparam int PtrWidth      = 2;
    localparam int CountWidth    = 3;

    // Frame checks.
    localparam logic [CategoryWidth-1:0] CAT_SELF_PROTECTED = 8'd15;
    localparam logic [LengthWidth-1:0]   MIN_BODY_LEN       = 12'd5;

    // Action codes.
    localparam logic [CodeWidth-1:0] CODE_OPEN    = 8'd1;
    localparam logic [CodeWidth-1:0] CODE_CONFIRM = 8'd2;
    localparam logic [CodeWidth-1:0] CODE_CLOSE   = 8'd3;

    // Peering states.
    localparam logic [StateWidth-1:0] ST_LISTEN    = 3'd0;
    localparam logic [StateWidth-1:0] ST_OPEN_SENT = 3'd1;
    localparam logic [StateWidth-1:0] ST_OPEN_RCVD = 3'd2;
    localparam logic [StateWidth-1:0] ST_CNF_RCVD  = 3'd3;
    localparam logic [StateWidth-1:0] ST_ESTAB     = 3'd4;
    localparam logic [StateWidth-1:0] ST_HOLDING   = 3'd5;
    localparam logic [StateWidth-1:0] ST_BLOCKED   = 3'd6;

    // Frames to transmit.
    localparam logic [SendWidth-1:0] TX_OPEN    = 2'd0;
    localparam logic [SendWidth-1:0] TX_CONFIRM = 2'd1;
    localparam logic [SendWidth-1:0] TX_CLOSE   = 2'd2;

    // One queued result.
    typedef struct packed {
        logic [SendWidth-1:0]  send_type;
        logic [StateWidth-1:0] link_state;
        logic                  last;
    } result_t;

endpackage

// File: rtl/mesh_peer_link_fsm.sv
// Peering link state machine for one mesh peer, with input stage and result queue.
`timescale 1ns / 1ps

// A request is registered in the input stage at acceptance and evaluated into the result
// queue once the queue has room for two results; its first result then drives the output.
// Throughput: one request per cycle while the queue has room for two results; the output
// port drains one result per cycle unless stalled, so two-frame requests back up the input.
// Reset: peer state returns to listen, the stored peer id and local id clear to zero,
// and the input stage and result queue empty at once; no clearing pass is needed.
module mesh_peer_link_fsm (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mpl_pkg::LinkIdWidth-1:0]        local_link_id,
    // Request channel.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mpl_pkg::CategoryWidth-1:0]      category,
    input  logic [mpl_pkg::LengthWidth-1:0]        frame_length,
    input  logic [mpl_pkg::CodeWidth-1:0]          frame_code,
    input  logic [mpl_pkg::LinkIdWidth-1:0]        peer_link_id,
    input  logic [mpl_pkg::LinkIdWidth-1:0]        local_id_in_frame,
    input  logic                                   links_available,
    // Result channel.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [mpl_pkg::SendWidth-1:0]          send_type,
    output logic [mpl_pkg::StateWidth-1:0]         link_state,
    output logic                                   last
);

    // Configuration register.
    logic [mpl_pkg::LinkIdWidth-1:0]   local_id_reg;

    // Input stage.
    logic                              stage_valid_reg;
    logic [mpl_pkg::CategoryWidth-1:0] category_reg;
    logic [mpl_pkg::LengthWidth-1:0]   length_reg;
    logic [mpl_pkg::CodeWidth-1:0]     code_reg;
    logic [mpl_pkg::LinkIdWidth-1:0]   plid_reg;
    logic [mpl_pkg::LinkIdWidth-1:0]   llid_reg;
    logic                              avail_reg;

    // Link state.
    logic [mpl_pkg::StateWidth-1:0]    peer_state_reg;
    logic [mpl_pkg::StateWidth-1:0]    peer_state_next;
    logic [mpl_pkg::LinkIdWidth-1:0]   stored_peer_id_reg;
    logic [mpl_pkg::LinkIdWidth-1:0]   stored_peer_id_next;

    // Result queue.
    mpl_pkg::result_t                  queue_reg [mpl_pkg::QueueDepth];
    logic [mpl_pkg::PtrWidth-1:0]      wr_ptr_reg;
    logic [mpl_pkg::PtrWidth-1:0]      rd_ptr_reg;
    logic [mpl_pkg::CountWidth-1:0]    count_reg;
    logic [mpl_pkg::CountWidth-1:0]    count_next;

    // Handshake and evaluation signals.
    logic                              in_accept;
    logic                              out_pop;
    logic                              room;
    logic                              proc;
    logic                              frame_ok;
    logic                              ev_open;
    logic                              ev_confirm;
    logic                              ev_close;
    logic [1:0]                        num_tx;
    logic [mpl_pkg::SendWidth-1:0]     tx0;
    logic [mpl_pkg::SendWidth-1:0]     tx1;
    mpl_pkg::result_t                  head;

    // Handshakes: the stage moves on whenever the queue can take two results.
    assign cfg_ready = 1'b1;
    assign room      = (count_reg <= mpl_pkg::CountWidth'(mpl_pkg::QueueDepth - 2));
    assign proc      = stage_valid_reg && room;
    assign in_stall  = stage_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_pop   = out_valid && !out_stall;

    // Queue head drives the result ports.
    assign head       = queue_reg[rd_ptr_reg];
    assign send_type  = head.send_type;
    assign link_state = head.link_state;
    assign last       = head.last;

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_id_reg <= local_link_id;
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            category_reg <= category;
            length_reg   <= frame_length;
            code_reg     <= frame_code;
            plid_reg     <= peer_link_id;
            llid_reg     <= local_id_in_frame;
            avail_reg    <= links_available;
        end
    end

    // Classify the frame into an accepted event.
    always_comb
    begin
        ev_open             = 1'b0;
        ev_confirm          = 1'b0;
        ev_close            = 1'b0;
        stored_peer_id_next = stored_peer_id_reg;
        frame_ok = (category_reg == mpl_pkg::CAT_SELF_PROTECTED)
                && (length_reg >= mpl_pkg::MIN_BODY_LEN)
                && (peer_state_reg != mpl_pkg::ST_BLOCKED);
        if (proc && frame_ok)
        begin
            case (code_reg)
                mpl_pkg::CODE_OPEN:
                begin
                    if (avail_reg && (stored_peer_id_reg == '0
                                      || stored_peer_id_reg == plid_reg))
                    begin
                        ev_open             = 1'b1;
                        stored_peer_id_next = plid_reg;
                    end
                end
                mpl_pkg::CODE_CONFIRM:
                begin
                    ev_confirm = avail_reg && (llid_reg == local_id_reg)
                              && (plid_reg == stored_peer_id_reg);
                end
                mpl_pkg::CODE_CLOSE:
                begin
                    ev_close = (peer_state_reg == mpl_pkg::ST_ESTAB)
                            || (plid_reg == stored_peer_id_reg);
                end
                default:
                begin
                    ev_open = 1'b0;
                end
            endcase
        end
    end

    // Peering state transitions and frames to send.
    always_comb
    begin
        peer_state_next = peer_state_reg;
        num_tx          = 2'd0;
        tx0             = mpl_pkg::TX_OPEN;
        tx1             = mpl_pkg::TX_CONFIRM;
        unique case (peer_state_reg)
            mpl_pkg::ST_LISTEN:
            begin
                if (ev_open)
                begin
                    peer_state_next = mpl_pkg::ST_OPEN_RCVD;
                    num_tx          = 2'd2;
                    tx0             = mpl_pkg::TX_OPEN;
                    tx1             = mpl_pkg::TX_CONFIRM;
                end
            end
            mpl_pkg::ST_OPEN_SENT:
            begin
                if (ev_open)
                begin
                    peer_state_next = mpl_pkg::ST_OPEN_RCVD;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CONFIRM;
                end
                else if (ev_confirm)
                begin
                    peer_state_next = mpl_pkg::ST_CNF_RCVD;
                end
                else if (ev_close)
                begin
                    peer_state_next = mpl_pkg::ST_HOLDING;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CLOSE;
                end
            end
            mpl_pkg::ST_OPEN_RCVD:
            begin
                if (ev_open)
                begin
                    num_tx = 2'd1;
                    tx0    = mpl_pkg::TX_CONFIRM;
                end
                else if (ev_confirm)
                begin
                    peer_state_next = mpl_pkg::ST_ESTAB;
                end
                else if (ev_close)
                begin
                    peer_state_next = mpl_pkg::ST_HOLDING;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CLOSE;
                end
            end
            mpl_pkg::ST_CNF_RCVD:
            begin
                if (ev_open)
                begin
                    peer_state_next = mpl_pkg::ST_ESTAB;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CONFIRM;
                end
                else if (ev_close)
                begin
                    peer_state_next = mpl_pkg::ST_HOLDING;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CLOSE;
                end
            end
            mpl_pkg::ST_ESTAB:
            begin
                if (ev_open)
                begin
                    num_tx = 2'd1;
                    tx0    = mpl_pkg::TX_CONFIRM;
                end
                else if (ev_close)
                begin
                    peer_state_next = mpl_pkg::ST_HOLDING;
                    num_tx          = 2'd1;
                    tx0             = mpl_pkg::TX_CLOSE;
                end
            end
            mpl_pkg::ST_HOLDING:
            begin
                if (ev_close)
                begin
                    peer_state_next = mpl_pkg::ST_LISTEN;
                end
                else if (ev_open || ev_confirm)
                begin
                    num_tx = 2'd1;
                    tx0    = mpl_pkg::TX_CLOSE;
                end
            end
            default:
            begin
                peer_state_next = peer_state_reg;
            end
        endcase
    end

    // Link state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_state_reg     <= mpl_pkg::ST_LISTEN;
            stored_peer_id_reg <= '0;
        end
        else
        begin
            peer_state_reg     <= peer_state_next;
            stored_peer_id_reg <= stored_peer_id_next;
        end
    end

    // Result queue occupancy.
    assign count_next = count_reg + {1'b0, num_tx}
                      - {{(mpl_pkg::CountWidth-1){1'b0}}, out_pop};

    // Result queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + num_tx;
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    // Result queue storage; each result carries the state after the step.
    always_ff @(posedge clk)
    begin
        if (num_tx != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= '{send_type:  tx0,
                                       link_state: peer_state_next,
                                       last:       (num_tx == 2'd1)};
        end
        if (num_tx == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= '{send_type:  tx1,
                                              link_state: peer_state_next,
                                              last:       1'b1};
        end
    end

    // Checks on the queue and the peering state.
    `include "mesh_peer_link_fsm_assert.svh"

    `MPL_ASSERT_ALWAYS(a_count_bound, count_reg <= mpl_pkg::CountWidth'(mpl_pkg::QueueDepth), "result queue overflow")
    `MPL_ASSERT_ALWAYS(a_never_blocked, peer_state_reg != mpl_pkg::ST_BLOCKED, "blocked state entered")
    `MPL_ASSERT_IMPL(a_pair_whole, out_valid && !last, count_reg >= 3'd2, "first frame of a pair without its second")
    `MPL_ASSERT_NEXT(a_state_hold, !proc, $stable(peer_state_reg), "state changed without a request")
    `MPL_ASSERT_IMPL(a_no_tx_idle, !proc, num_tx == 2'd0, "frames queued without a request")

endmodule
